### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro takes a label, the clock,
// the reset and the property terms; the synthesis branch expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SQB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sqb assertion failed");
`define SQB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sqb implication failed");
`define SQB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sqb next-cycle check failed");
`else
`define SQB_ASSERT(label, clk, rst, prop)
`define SQB_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SQB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/sqb_pkg.sv
package sqb_pkg;

   // Batch limits
   localparam int TEXTURE_SLOTS    = 16;
   localparam int MAX_QUADS        = 1024;
   localparam int INDICES_PER_QUAD = 6;
   localparam int QUAD_LIMIT       = INDICES_PER_QUAD * MAX_QUADS;

   localparam int SLOT_IDX_W = $clog2(TEXTURE_SLOTS);
   localparam int SLOT_CNT_W = $clog2(TEXTURE_SLOTS + 1);
   localparam int IDX_CNT_W  = $clog2(QUAD_LIMIT + 1);

   // Fixed field widths
   localparam int SLOT_W = 4;
   localparam int DRAW_W = 13;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Request operations
   localparam logic [1:0] OP_DRAW  = 2'd0;
   localparam logic [1:0] OP_BEGIN = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_BIND   = 2'd1;
   localparam logic [1:0] KIND_DRAW   = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] mat_xx;
      logic signed [31:0] mat_xy;
      logic signed [31:0] mat_xt;
      logic signed [31:0] mat_yx;
      logic signed [31:0] mat_yy;
      logic signed [31:0] mat_yt;
      logic signed [31:0] mat_zx;
      logic signed [31:0] mat_zy;
      logic signed [31:0] mat_zt;
      logic [31:0]        texture_handle;
      logic [31:0]        color_rgba;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               tex_u;
      logic               tex_v;
      logic [31:0]        vertex_color;
      logic [SLOT_W-1:0]  slot;
      logic [31:0]        bound_handle;
      logic [DRAW_W-1:0]  draw_indices;
      logic               last;
   } rsp_type;

   // One queued job: a quad, a slot bind or a draw command
   typedef struct packed {
      logic [1:0]         kind;
      logic               last;
      logic signed [31:0] mat_xx;
      logic signed [31:0] mat_xy;
      logic signed [31:0] mat_xt;
      logic signed [31:0] mat_yx;
      logic signed [31:0] mat_yy;
      logic signed [31:0] mat_yt;
      logic signed [31:0] mat_zx;
      logic signed [31:0] mat_zy;
      logic signed [31:0] mat_zt;
      logic [31:0]        color;
      logic [SLOT_W-1:0]  slot;
      logic [31:0]        handle;
      logic [DRAW_W-1:0]  indices;
   } job_type;

   // Slot table index as carried in a result
   function automatic logic [SLOT_W-1:0] to_slot_field(input logic [SLOT_IDX_W-1:0] idx);
      return SLOT_W'(idx);
   endfunction

endpackage

### rtl/sqb_front.sv
module sqb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sqb_pkg::req_type req_data,
   output logic             push_valid,
   output sqb_pkg::job_type push_job,
   input  logic             queue_full
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_BIND  = 2'd2;
   localparam logic [1:0] ST_DRAW  = 2'd3;

   logic [1:0]                       state_ff, state_in;
   sqb_pkg::req_type                 req_ff, req_in;
   logic [sqb_pkg::SLOT_CNT_W-1:0]   slots_used_ff, slots_used_in;
   logic [sqb_pkg::IDX_CNT_W-1:0]    index_total_ff, index_total_in;
   logic [sqb_pkg::SLOT_IDX_W-1:0]   bind_cnt_ff, bind_cnt_in;
   logic [31:0]                      handles_ff [sqb_pkg::TEXTURE_SLOTS];
   logic [31:0]                      handles_in [sqb_pkg::TEXTURE_SLOTS];

   logic                             hit;
   logic [sqb_pkg::SLOT_IDX_W-1:0]   hit_idx;
   logic [sqb_pkg::SLOT_IDX_W-1:0]   new_idx;
   logic                             quad_full;
   logic                             table_full;
   logic                             batch_empty;
   logic                             bind_done;
   sqb_pkg::job_type                 quad_job;

   assign req_stall = (state_ff != ST_IDLE);

   // Hold the request while it is classified
   assign req_in = (state_ff == ST_IDLE && req_valid) ? req_data : req_ff;

   // Search the used slots, lowest match wins
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = sqb_pkg::TEXTURE_SLOTS - 1; i >= 0; i--) begin
         if (sqb_pkg::SLOT_CNT_W'(i) < slots_used_ff &&
             handles_ff[i] == req_ff.texture_handle) begin
            hit     = 1'b1;
            hit_idx = sqb_pkg::SLOT_IDX_W'(i);
         end
      end
   end

   assign new_idx     = slots_used_ff[sqb_pkg::SLOT_IDX_W-1:0];
   assign quad_full   = (index_total_ff >= sqb_pkg::IDX_CNT_W'(sqb_pkg::QUAD_LIMIT));
   assign table_full  = (slots_used_ff >= sqb_pkg::SLOT_CNT_W'(sqb_pkg::TEXTURE_SLOTS));
   assign batch_empty = (index_total_ff == '0);
   assign bind_done   = (sqb_pkg::SLOT_CNT_W'(bind_cnt_ff) + sqb_pkg::SLOT_CNT_W'(1)
                         == slots_used_ff);

   // Quad job for the current sprite
   always_comb begin
      quad_job        = '0;
      quad_job.kind   = sqb_pkg::KIND_VERTEX;
      quad_job.last   = 1'b1;
      quad_job.mat_xx = req_ff.mat_xx;
      quad_job.mat_xy = req_ff.mat_xy;
      quad_job.mat_xt = req_ff.mat_xt;
      quad_job.mat_yx = req_ff.mat_yx;
      quad_job.mat_yy = req_ff.mat_yy;
      quad_job.mat_yt = req_ff.mat_yt;
      quad_job.mat_zx = req_ff.mat_zx;
      quad_job.mat_zy = req_ff.mat_zy;
      quad_job.mat_zt = req_ff.mat_zt;
      quad_job.color  = req_ff.color_rgba;
      quad_job.slot   = sqb_pkg::to_slot_field(hit ? hit_idx : new_idx);
   end

   // Classify, allocate slots and sequence flushes
   always_comb begin
      state_in       = state_ff;
      slots_used_in  = slots_used_ff;
      index_total_in = index_total_ff;
      bind_cnt_in    = bind_cnt_ff;
      handles_in     = handles_ff;
      push_valid     = 1'b0;
      push_job       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            unique case (req_ff.operation)
               sqb_pkg::OP_BEGIN: begin
                  index_total_in = '0;
                  slots_used_in  = sqb_pkg::SLOT_CNT_W'(1);
                  state_in       = ST_IDLE;
               end
               sqb_pkg::OP_END: begin
                  bind_cnt_in = '0;
                  state_in    = batch_empty ? ST_IDLE : ST_BIND;
               end
               sqb_pkg::OP_DRAW: begin
                  if (quad_full) begin
                     bind_cnt_in = '0;
                     state_in    = ST_BIND;
                  end else if (hit || !table_full) begin
                     if (!queue_full) begin
                        push_valid     = 1'b1;
                        push_job       = quad_job;
                        index_total_in = index_total_ff +
                                         sqb_pkg::IDX_CNT_W'(sqb_pkg::INDICES_PER_QUAD);
                        if (!hit) begin
                           handles_in[new_idx] = req_ff.texture_handle;
                           slots_used_in       = slots_used_ff + sqb_pkg::SLOT_CNT_W'(1);
                        end
                        state_in = ST_IDLE;
                     end
                  end else if (!batch_empty) begin
                     bind_cnt_in = '0;
                     state_in    = ST_BIND;
                  end else begin
                     // nothing to flush: just start over
                     index_total_in = '0;
                     slots_used_in  = sqb_pkg::SLOT_CNT_W'(1);
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_BIND: begin
            if (!queue_full) begin
               push_valid      = 1'b1;
               push_job.kind   = sqb_pkg::KIND_BIND;
               push_job.slot   = sqb_pkg::to_slot_field(bind_cnt_ff);
               push_job.handle = handles_ff[bind_cnt_ff];
               if (bind_done) begin
                  state_in = ST_DRAW;
               end else begin
                  bind_cnt_in = bind_cnt_ff + sqb_pkg::SLOT_IDX_W'(1);
               end
            end
         end
         ST_DRAW: begin
            if (!queue_full) begin
               push_valid       = 1'b1;
               push_job.kind    = sqb_pkg::KIND_DRAW;
               push_job.indices = sqb_pkg::DRAW_W'(index_total_ff);
               push_job.last    = (req_ff.operation == sqb_pkg::OP_END);
               if (req_ff.operation == sqb_pkg::OP_END) begin
                  state_in = ST_IDLE;
               end else begin
                  // flushed ahead of a sprite: restart the batch, look up again
                  index_total_in = '0;
                  slots_used_in  = sqb_pkg::SLOT_CNT_W'(1);
                  state_in       = ST_CHECK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         slots_used_ff  <= sqb_pkg::SLOT_CNT_W'(1);
         index_total_ff <= '0;
         bind_cnt_ff    <= '0;
         for (int i = 0; i < sqb_pkg::TEXTURE_SLOTS; i++) begin
            handles_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         slots_used_ff  <= slots_used_in;
         index_total_ff <= index_total_in;
         bind_cnt_ff    <= bind_cnt_in;
         handles_ff     <= handles_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

endmodule

### rtl/sqb_job_queue.sv
module sqb_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  sqb_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output sqb_pkg::job_type head,
   output logic             empty
);

   sqb_pkg::job_type                entries_ff [sqb_pkg::QUEUE_DEPTH];
   sqb_pkg::job_type                entries_in [sqb_pkg::QUEUE_DEPTH];
   logic [sqb_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sqb_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sqb_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign full    = (count_ff == sqb_pkg::QUEUE_CNT_W'(sqb_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         entries_in[wr_ptr_ff] = push_job;
         wr_ptr_in = (wr_ptr_ff == sqb_pkg::QUEUE_PTR_W'(sqb_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + sqb_pkg::QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sqb_pkg::QUEUE_PTR_W'(sqb_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + sqb_pkg::QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + sqb_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - sqb_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

endmodule

### rtl/sqb_back.sv
module sqb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  sqb_pkg::job_type job_head,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sqb_pkg::rsp_type rsp_data
);

   // Job in progress; rows keep 2t-c0 and 2t+c0 so a corner needs one add
   typedef struct packed {
      logic [1:0]                  kind;
      logic                        last;
      logic [31:0]                 color;
      logic [sqb_pkg::SLOT_W-1:0]  slot;
      logic [31:0]                 handle;
      logic [sqb_pkg::DRAW_W-1:0]  indices;
      logic [33:0]                 x_lo;
      logic [33:0]                 x_hi;
      logic [31:0]                 x_c1;
      logic [33:0]                 y_lo;
      logic [33:0]                 y_hi;
      logic [31:0]                 y_c1;
      logic [33:0]                 z_lo;
      logic [33:0]                 z_hi;
      logic [31:0]                 z_c1;
   } back_work_type;

   back_work_type    work_ff, work_in;
   logic             work_valid_ff, work_valid_in;
   logic [1:0]       corner_ff, corner_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sqb_pkg::rsp_type rsp_ff, rsp_in;
   sqb_pkg::rsp_type result;
   back_work_type    loaded;
   logic             advance;
   logic             emit;
   logic             finishing;
   logic             load;
   logic             sx;
   logic             sy;

   // Corner position: halve (base +- c1) toward minus infinity, saturate to 32 bits
   function automatic logic [31:0] corner_pos(input logic [33:0] lo,
                                              input logic [33:0] hi,
                                              input logic [31:0] c1,
                                              input logic        px,
                                              input logic        py);
      logic [34:0] base;
      logic [34:0] term;
      logic [34:0] sum;
      logic [33:0] half;
      base = px ? {hi[33], hi} : {lo[33], lo};
      term = {{3{c1[31]}}, c1};
      sum  = py ? base + term : base - term;
      half = sum[34:1];
      if (half[33:31] == 3'b000 || half[33:31] == 3'b111) begin
         return half[31:0];
      end
      return half[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Corner order (-,-) (+,-) (+,+) (-,+)
   assign sx = corner_ff[0] ^ corner_ff[1];
   assign sy = corner_ff[1];

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign emit      = work_valid_ff && advance;
   assign finishing = emit && (work_ff.kind != sqb_pkg::KIND_VERTEX || corner_ff == 2'd3);
   assign load      = job_valid && (!work_valid_ff || finishing);
   assign job_pop   = load;

   // Pre-add the translation and first column of each row
   always_comb begin
      loaded         = '0;
      loaded.kind    = job_head.kind;
      loaded.last    = job_head.last;
      loaded.color   = job_head.color;
      loaded.slot    = job_head.slot;
      loaded.handle  = job_head.handle;
      loaded.indices = job_head.indices;
      loaded.x_lo = {job_head.mat_xt[31], job_head.mat_xt, 1'b0} -
                    {{2{job_head.mat_xx[31]}}, job_head.mat_xx};
      loaded.x_hi = {job_head.mat_xt[31], job_head.mat_xt, 1'b0} +
                    {{2{job_head.mat_xx[31]}}, job_head.mat_xx};
      loaded.x_c1 = job_head.mat_xy;
      loaded.y_lo = {job_head.mat_yt[31], job_head.mat_yt, 1'b0} -
                    {{2{job_head.mat_yx[31]}}, job_head.mat_yx};
      loaded.y_hi = {job_head.mat_yt[31], job_head.mat_yt, 1'b0} +
                    {{2{job_head.mat_yx[31]}}, job_head.mat_yx};
      loaded.y_c1 = job_head.mat_yy;
      loaded.z_lo = {job_head.mat_zt[31], job_head.mat_zt, 1'b0} -
                    {{2{job_head.mat_zx[31]}}, job_head.mat_zx};
      loaded.z_hi = {job_head.mat_zt[31], job_head.mat_zt, 1'b0} +
                    {{2{job_head.mat_zx[31]}}, job_head.mat_zx};
      loaded.z_c1 = job_head.mat_zy;
   end

   // Build the next result beat
   always_comb begin
      result      = '0;
      result.kind = work_ff.kind;
      case (work_ff.kind)
         sqb_pkg::KIND_VERTEX: begin
            result.pos_x        = corner_pos(work_ff.x_lo, work_ff.x_hi, work_ff.x_c1, sx, sy);
            result.pos_y        = corner_pos(work_ff.y_lo, work_ff.y_hi, work_ff.y_c1, sx, sy);
            result.pos_z        = corner_pos(work_ff.z_lo, work_ff.z_hi, work_ff.z_c1, sx, sy);
            result.tex_u        = sx;
            result.tex_v        = sy;
            result.vertex_color = work_ff.color;
            result.slot         = work_ff.slot;
            result.last         = work_ff.last && (corner_ff == 2'd3);
         end
         sqb_pkg::KIND_BIND: begin
            result.slot         = work_ff.slot;
            result.bound_handle = work_ff.handle;
            result.last         = work_ff.last;
         end
         sqb_pkg::KIND_DRAW: begin
            result.draw_indices = work_ff.indices;
            result.last         = work_ff.last;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // Step corners, swap in the next job as the current one drains
   always_comb begin
      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      corner_in     = corner_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      if (load) begin
         work_in       = loaded;
         work_valid_in = 1'b1;
         corner_in     = 2'd0;
      end else if (finishing) begin
         work_valid_in = 1'b0;
      end else if (emit) begin
         corner_in = corner_ff + 2'd1;
      end
      if (advance) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         rsp_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         corner_ff     <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         corner_ff     <= corner_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rsp_ff  <= rsp_in;
   end

endmodule

### rtl/sprite_quad_batcher_unit.sv
// beat      dir  valid / stall          payload
// request   in   req_valid / req_stall  sqb_pkg::req_type (draw, begin, end)
// result    out  rsp_valid / rsp_stall  sqb_pkg::rsp_type (vertex, bind, draw)
//
// A request is registered and then classified; the front takes no new request
// until it has classified the last one. The back emits one result beat per cycle
// while rsp_stall is low, four vertex beats per sprite. A flush adds one beat per
// used slot plus one for the draw command, sequenced through the slot table.
// Reset empties the batch: slot 0 holds handle 0, no indices counted.
// A stalled result holds in the output register; the four-job queue lets the
// front keep classifying until it fills, after which the front holds req_stall high.
`include "assert_macros.svh"

module sprite_quad_batcher_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sqb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sqb_pkg::rsp_type rsp_data
);

   logic             q_push;
   sqb_pkg::job_type q_job;
   logic             q_full;
   logic             q_pop;
   sqb_pkg::job_type q_head;
   logic             q_empty;

   sqb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (q_push),
      .push_job   (q_job),
      .queue_full (q_full)
   );

   sqb_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_job   (q_job),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   sqb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!q_empty),
      .job_head  (q_head),
      .job_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Queue is never overrun or drained past empty
   `SQB_ASSERT_IMPL(a_push_has_room, clock, reset, q_push, !q_full)
   `SQB_ASSERT_IMPL(a_pop_has_job, clock, reset, q_pop, !q_empty)
   // A draw command always carries indices; a bind never ends a request
   `SQB_ASSERT_IMPL(a_draw_not_empty, clock, reset, rsp_valid && rsp_data.kind == sqb_pkg::KIND_DRAW, rsp_data.draw_indices != '0)
   `SQB_ASSERT_IMPL(a_bind_not_last, clock, reset, rsp_valid && rsp_data.kind == sqb_pkg::KIND_BIND, !rsp_data.last)

endmodule
